>>> rtl/mandelbrot_escape_pixel_assert.svh
// assertion macros for the mandelbrot escape pixel block
`ifndef MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define MEP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MEP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MEP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define MEP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/mep_pkg.sv
// types, widths and constants of the mandelbrot escape pixel block
package mep_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 12;

  localparam int PIX_W     = 12;
  localparam int CFG_W     = 32;
  localparam int SIZE_W    = 13;
  localparam int ITER_W    = 16;
  localparam int CFG_IDX_W = 3;

  // kept z stays below two in magnitude, its square below four
  localparam int Z_W       = FRAC_BITS + 2;
  localparam int SQ_W      = FRAC_BITS + 2;
  localparam int N_W       = ((FRAC_BITS + 3 > CFG_W) ? FRAC_BITS + 3 : CFG_W) + 2;
  localparam int SPAN_W    = CFG_W + 1;
  localparam int MUL_W     = (Z_W > SPAN_W) ? Z_W : SPAN_W;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIVD_W    = CFG_W + COORD_BITS;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
  localparam int SUM_W     = DIVD_W + 2;

  localparam logic signed [CFG_W-1:0] X_MIN_RST = 32'shE000_0000;
  localparam logic signed [CFG_W-1:0] X_MAX_RST = 32'sh1000_0000;
  localparam logic signed [CFG_W-1:0] Y_MIN_RST = 32'shF000_0000;
  localparam logic signed [CFG_W-1:0] Y_MAX_RST = 32'sh1000_0000;
  localparam logic [SIZE_W-1:0]       WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0]       HEIGHT_RST = 13'd480;
  localparam logic [ITER_W-1:0]       ITER_RST   = 16'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN,
    CFG_X_MAX,
    CFG_Y_MIN,
    CFG_Y_MAX,
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_MAX_ITER
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_DIV,
    S_MAP_ADD,
    S_IT_ZZ,
    S_IT_RR,
    S_IT_II,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [ITER_W-1:0] escape_count;
    logic              inside_set;
  } pixel_out_t;

endpackage

>>> rtl/mandelbrot_escape_pixel.sv
// mandelbrot escape-time evaluator for one pixel per transfer
//
// input channel in_valid/in_stall/in_data carries a pixel column and row; the
// result channel out_valid/out_stall/out_data returns the escape count and the
// inside flag. cfg_we/cfg_index/cfg_wdata write the plane edges, the image
// size and the iteration limit; the user must do so only while no pixel is
// in flight, as the block does not enforce it. a pixel is taken only when
// the block is idle (in_stall low). it is mapped to the plane one axis after
// the other: one product on the shared multiplier and a one-bit-per-cycle
// divider of 44 steps per axis. each iteration then runs on the single 33x33
// multiplier (zr*zi, then the square of the new real and imaginary parts); a
// point whose new z leaves the radius-two box escapes after the first of them.
// the next pixel is taken the cycle after a result is handed to the output
// register, where it waits, so a stalled receiver does not hold up the next
// pixel, only the hand-over of the one after.
// reset returns the registers to a plane of -2..1 by -1..1, 640x480 pixels
// and a limit of 255, and leaves the block idle with no result pending;
// in_stall stays high while reset is held.
`include "mandelbrot_escape_pixel_assert.svh"

module mandelbrot_escape_pixel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mep_pkg::pixel_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mep_pkg::pixel_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mep_pkg::CFG_W-1:0]           cfg_wdata
);
  import mep_pkg::*;

  localparam logic signed [N_W-1:0]   Z_LIM     = N_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [N_W-1:0]   Z_LIM_NEG = -Z_LIM;
  localparam logic signed [SUM_W-1:0] C_MAX     = SUM_W'({1'b0, {(CFG_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] C_MIN     = ~C_MAX;

  logic signed [CFG_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [SIZE_W-1:0]       width_r, height_r;
  logic [ITER_W-1:0]       max_iter_r;

  state_t state_r, state_nxt;

  logic                    axis_r;
  logic [COORD_BITS-1:0]   px_r, py_r;
  logic [ITER_W-1:0]       lim_r;
  logic signed [CFG_W-1:0] cr_r, ci_r;
  logic                    map_neg_r;
  logic [DIVD_W-1:0]       quo_r;
  logic [SIZE_W-1:0]       rem_r;
  logic [SIZE_W-1:0]       div_d_r;
  logic [DIV_CNT_W-1:0]    div_cnt_r;
  logic signed [Z_W-1:0]   zr_r, zi_r;
  logic [SQ_W-1:0]         sqr_r, sqi_r;
  logic signed [N_W-1:0]   nr_r, ni_r;
  logic [ITER_W-1:0]       iter_r;
  logic                    out_valid_r;
  pixel_out_t              out_data_r;

  logic signed [SPAN_W-1:0] span;
  logic signed [CFG_W-1:0]  axis_min;
  logic [SIZE_W-1:0]        axis_size;
  logic [SIZE_W-1:0]        div_d;
  logic [COORD_BITS-1:0]    axis_pix;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0]        mul_abs;
  logic [SIZE_W:0]          div_shift;
  logic [SIZE_W+1:0]        div_diff;
  logic                     div_ok;
  logic signed [SUM_W-1:0]  q_signed, c_sum, c_sat;
  logic signed [N_W-1:0]    nr_c, ni_c;
  logic                     big;
  logic [SQ_W-1:0]          sq_c;
  logic [SQ_W:0]            sq_sum;
  logic                     escape;
  logic                     out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= X_MIN_RST;
      x_max_r    <= X_MAX_RST;
      y_min_r    <= Y_MIN_RST;
      y_max_r    <= Y_MAX_RST;
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      max_iter_r <= ITER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_MIN:    x_min_r    <= cfg_wdata;
        CFG_X_MAX:    x_max_r    <= cfg_wdata;
        CFG_Y_MIN:    y_min_r    <= cfg_wdata;
        CFG_Y_MAX:    y_max_r    <= cfg_wdata;
        CFG_WIDTH:    width_r    <= SIZE_W'(cfg_wdata);
        CFG_HEIGHT:   height_r   <= SIZE_W'(cfg_wdata);
        CFG_MAX_ITER: max_iter_r <= ITER_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // axis selection for the mapping
  always_comb begin
    if (axis_r) begin
      span      = SPAN_W'(y_max_r) - SPAN_W'(y_min_r);
      axis_min  = y_min_r;
      axis_size = height_r;
      axis_pix  = py_r;
    end else begin
      span      = SPAN_W'(x_max_r) - SPAN_W'(x_min_r);
      axis_min  = x_min_r;
      axis_size = width_r;
      axis_pix  = px_r;
    end
    div_d = (axis_size == '0) ? SIZE_W'(1) : axis_size;
  end

  // shared multiplier
  always_comb begin
    case (state_r)
      S_MAP_MUL: begin
        mul_a = MUL_W'(span);
        mul_b = $signed(MUL_W'(axis_pix));
      end
      S_IT_ZZ: begin
        mul_a = MUL_W'(zr_r);
        mul_b = MUL_W'(zi_r);
      end
      S_IT_RR: begin
        mul_a = MUL_W'(Z_W'(nr_r));
        mul_b = MUL_W'(Z_W'(nr_r));
      end
      S_IT_II: begin
        mul_a = MUL_W'(Z_W'(ni_r));
        mul_b = MUL_W'(Z_W'(ni_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_abs = mul_p[PROD_W-1] ? PROD_W'(-mul_p) : PROD_W'(mul_p);

  // restoring divider step
  assign div_shift = {rem_r, quo_r[DIVD_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, div_d_r};
  assign div_ok    = !div_diff[SIZE_W+1];

  // mapped coordinate with saturation
  always_comb begin
    q_signed = $signed({2'b00, quo_r});
    if (map_neg_r) begin
      q_signed = -q_signed;
    end
    c_sum = SUM_W'(axis_min) + q_signed;
    if (c_sum > C_MAX) begin
      c_sat = C_MAX;
    end else if (c_sum < C_MIN) begin
      c_sat = C_MIN;
    end else begin
      c_sat = c_sum;
    end
  end

  // iteration arithmetic
  assign nr_c = N_W'($signed({1'b0, sqr_r})) - N_W'($signed({1'b0, sqi_r})) + N_W'(cr_r);
  assign ni_c = N_W'(mul_p >>> (FRAC_BITS - 1)) + N_W'(ci_r);
  assign big  = (nr_c >= Z_LIM) || (nr_c <= Z_LIM_NEG) ||
                (ni_c >= Z_LIM) || (ni_c <= Z_LIM_NEG);
  assign sq_c   = SQ_W'(mul_p >>> FRAC_BITS);
  assign sq_sum = {1'b0, sqr_r} + {1'b0, sq_c};
  assign escape = sq_sum[SQ_W];

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = !rst_n;
        if (in_valid) begin
          state_nxt = S_MAP_MUL;
        end
      end
      S_MAP_MUL: state_nxt = S_MAP_DIV;
      S_MAP_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(1)) begin
          state_nxt = S_MAP_ADD;
        end
      end
      S_MAP_ADD: state_nxt = axis_r ? S_IT_ZZ : S_MAP_MUL;
      S_IT_ZZ:   state_nxt = big ? S_DONE : S_IT_RR;
      S_IT_RR:   state_nxt = S_IT_II;
      S_IT_II: begin
        if (escape || (iter_r == lim_r)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_IT_ZZ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        px_r   <= COORD_BITS'(in_data.pixel_x);
        py_r   <= COORD_BITS'(in_data.pixel_y);
        lim_r  <= max_iter_r;
        axis_r <= 1'b0;
      end
      S_MAP_MUL: begin
        map_neg_r <= mul_p[PROD_W-1];
        quo_r     <= mul_abs[DIVD_W-1:0];
        rem_r     <= '0;
        div_d_r   <= div_d;
        div_cnt_r <= DIV_CNT_W'(DIVD_W);
      end
      S_MAP_DIV: begin
        rem_r     <= div_ok ? div_diff[SIZE_W-1:0] : div_shift[SIZE_W-1:0];
        quo_r     <= {quo_r[DIVD_W-2:0], div_ok};
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
      S_MAP_ADD: begin
        if (axis_r) begin
          ci_r <= CFG_W'(c_sat);
        end else begin
          cr_r <= CFG_W'(c_sat);
        end
        axis_r <= 1'b1;
        zr_r   <= '0;
        zi_r   <= '0;
        sqr_r  <= '0;
        sqi_r  <= '0;
        iter_r <= '0;
      end
      S_IT_ZZ: begin
        nr_r <= nr_c;
        ni_r <= ni_c;
      end
      S_IT_RR: begin
        sqr_r <= sq_c;
      end
      S_IT_II: begin
        sqi_r <= sq_c;
        zr_r  <= Z_W'(nr_r);
        zi_r  <= Z_W'(ni_r);
        if (!escape && (iter_r != lim_r)) begin
          iter_r <= iter_r + ITER_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r.escape_count <= iter_r;
      out_data_r.inside_set   <= (iter_r == lim_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MEP_ASSERT_IMP(a_iter_lim, clk, rst_n, state_r == S_IT_ZZ, iter_r <= lim_r, "iter past limit")
  `MEP_ASSERT_IMP(a_div_rem, clk, rst_n, state_r == S_MAP_DIV, rem_r < div_d_r, "rem too big")
  `MEP_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_DONE, "no pixel")

endmodule
